// File: rtl/ctls_pkg.sv
// ----------------------------------------------------------------------------
// Coupled tile lattice package
// Shared types, limits and helpers for the tile ring and its update unit.
// ----------------------------------------------------------------------------
package ctls_pkg;

	localparam int MAX_COLUMNS = 8;
	localparam int MAX_ROWS    = 8;
	localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
	localparam int IDX_W       = $clog2(CELLS);
	localparam int DIM_W       = 4;

	localparam logic signed [16:0] LIM_ANGLE  = 17'sd12868;
	localparam logic signed [16:0] LIM_ZOOM   = 17'sd4096;
	localparam logic signed [16:0] LIM_VANGLE = 17'sd3217;
	localparam logic signed [16:0] LIM_VZOOM  = 17'sd1024;

	localparam logic [2:0] REG_SPRING   = 3'd0;
	localparam logic [2:0] REG_COUPLING = 3'd1;
	localparam logic [2:0] REG_FRICTION = 3'd2;
	localparam logic [2:0] REG_COLUMNS  = 3'd3;
	localparam logic [2:0] REG_ROWS     = 3'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef struct packed {
		logic signed [14:0] a;
		logic signed [13:0] z;
		logic signed [12:0] va;
		logic signed [11:0] vz;
	} tile_t;

	typedef enum logic [1:0] {
		MAC_HOLD,
		MAC_SPRING,
		MAC_NEIGH,
		MAC_KEEP
	} mac_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_VEL,
		ST_POS
	} state_t;

	function automatic logic signed [16:0] clamp17(input logic signed [16:0] x,
		input logic signed [16:0] lim);
		logic signed [16:0] r;
		r = x;
		if (x > lim) begin
			r = lim;
		end else if (x < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

endpackage

// File: rtl/ctls_cell.sv
// ----------------------------------------------------------------------------
// Tile cell
// Holds one tile and passes it to its neighbor in the ring on a shift.
// ----------------------------------------------------------------------------
module ctls_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift_en,
	input  logic           load_en,
	input  ctls_pkg::tile_t next_d,
	input  ctls_pkg::tile_t load_d,
	output ctls_pkg::tile_t tile_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= '0;
		end else if (load_en) begin
			tile_q <= load_d;
		end else if (shift_en) begin
			tile_q <= next_d;
		end
	end

endmodule

// File: rtl/ctls_mac.sv
// ----------------------------------------------------------------------------
// Velocity update unit
// Accumulates spring, coupling and friction products for one channel.
// ----------------------------------------------------------------------------
module ctls_mac (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctls_pkg::mac_op_t      op,
	input  logic signed [15:0]     pos,
	input  logic signed [15:0]     nb_pos,
	input  logic signed [15:0]     vel,
	input  logic [16:0]            coef,
	input  logic signed [16:0]     lim,
	output logic signed [16:0]     vel_new
);

	logic signed [17:0] acc_q;
	logic signed [16:0] diff;
	logic signed [17:0] mul_a;
	logic signed [35:0] prod;
	logic signed [35:0] prod_sh;
	logic signed [17:0] term;
	logic signed [17:0] lim_w;

	assign diff    = {nb_pos[15], nb_pos} - {pos[15], pos};
	assign prod    = mul_a * $signed({1'b0, coef});
	assign prod_sh = prod >>> 16;
	assign term    = prod_sh[17:0];
	assign lim_w   = $signed({lim[16], lim});

	always_comb begin
		unique case (op)
			ctls_pkg::MAC_SPRING: mul_a = {{2{pos[15]}}, pos};
			ctls_pkg::MAC_NEIGH:  mul_a = {diff[16], diff};
			ctls_pkg::MAC_KEEP:   mul_a = acc_q;
			default:              mul_a = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			unique case (op)
				ctls_pkg::MAC_SPRING: acc_q <= {{2{vel[15]}}, vel} - term;
				ctls_pkg::MAC_NEIGH:  acc_q <= acc_q + term;
				ctls_pkg::MAC_KEEP:   acc_q <= term;
				default:              acc_q <= acc_q;
			endcase
		end
	end

	always_comb begin
		vel_new = acc_q[16:0];
		if (acc_q > lim_w) begin
			vel_new = lim;
		end else if (acc_q < -lim_w) begin
			vel_new = -lim;
		end
	end

endmodule

// File: rtl/coupled_tile_lattice_step.sv
// ----------------------------------------------------------------------------
// Coupled tile lattice step
// Ring of 64 tile cells; a load writes one cell, a step updates velocities
// in one rotation of the ring and positions in a second, emitting each active tile.
// In the velocity pass each active tile takes the spring, four neighbor and
// friction products in turn through the shared multiplier in each update unit,
// and an inactive cell is simply passed on; in the position pass a cell moves
// on when the output is free. A new load or step is accepted only while idle.
// Reset clears all tiles to zero and the registers to their defaults at once.
// ----------------------------------------------------------------------------
module coupled_tile_lattice_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tile_index, angle_in, zoom_in, angle_velocity_in, zoom_velocity_in, zero pad
	input  logic [63:0] s_tdata,
	// op
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tile_out, angle_out, zoom_out, zero pad
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CELLS = ctls_pkg::CELLS;
	localparam int IW    = ctls_pkg::IDX_W;
	localparam int DW    = ctls_pkg::DIM_W;

	ctls_pkg::state_t state_q, state_d;
	logic [15:0]   spring_q, coupling_q, friction_q;
	logic [DW-1:0] cols_q, rows_q, cols_eff, rows_eff;
	logic [IW-1:0] i_q;
	logic [DW-1:0] c_q, r_q;
	logic [2:0]    sub_q;
	logic          active, adv, emit, in_acc, phase_end;
	logic [16:0]   keep;

	ctls_pkg::tile_t cells [CELLS];
	ctls_pkg::tile_t upd, load_d, down_tap, up_tap, nb;
	ctls_pkg::mac_op_t op_a;
	logic signed [16:0] va_new, vz_new, a_sum, z_sum;
	logic          has_nb;

	assign cfg_ready = state_q == ctls_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_q   <= 16'd6554;
			coupling_q <= 16'd1638;
			friction_q <= 16'd3277;
			cols_q     <= 4'd8;
			rows_q     <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ctls_pkg::REG_SPRING:   spring_q   <= cfg_data;
				ctls_pkg::REG_COUPLING: coupling_q <= cfg_data;
				ctls_pkg::REG_FRICTION: friction_q <= cfg_data;
				ctls_pkg::REG_COLUMNS:  cols_q     <= cfg_data[DW-1:0];
				ctls_pkg::REG_ROWS:     rows_q     <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cols_eff = cols_q;
		if (cols_q == '0) begin
			cols_eff = DW'(1);
		end else if (cols_q > DW'(ctls_pkg::MAX_COLUMNS)) begin
			cols_eff = DW'(ctls_pkg::MAX_COLUMNS);
		end
		rows_eff = rows_q;
		if (rows_q == '0) begin
			rows_eff = DW'(1);
		end else if (rows_q > DW'(ctls_pkg::MAX_ROWS)) begin
			rows_eff = DW'(ctls_pkg::MAX_ROWS);
		end
	end

	assign keep = 17'h10000 - {1'b0, friction_q};

	assign load_d.a  = 15'(ctls_pkg::clamp17({{2{s_tdata[20]}}, s_tdata[20:6]},
		ctls_pkg::LIM_ANGLE));
	assign load_d.z  = 14'(ctls_pkg::clamp17({{3{s_tdata[34]}}, s_tdata[34:21]},
		ctls_pkg::LIM_ZOOM));
	assign load_d.va = 13'(ctls_pkg::clamp17({{4{s_tdata[47]}}, s_tdata[47:35]},
		ctls_pkg::LIM_VANGLE));
	assign load_d.vz = 12'(ctls_pkg::clamp17({{5{s_tdata[59]}}, s_tdata[59:48]},
		ctls_pkg::LIM_VZOOM));

	assign in_acc = s_tvalid && s_tready;
	assign active = r_q < rows_eff;

	always_comb begin
		unique case (cols_eff)
			4'd1:    begin down_tap = cells[1]; up_tap = cells[CELLS-1]; end
			4'd2:    begin down_tap = cells[2]; up_tap = cells[CELLS-2]; end
			4'd3:    begin down_tap = cells[3]; up_tap = cells[CELLS-3]; end
			4'd4:    begin down_tap = cells[4]; up_tap = cells[CELLS-4]; end
			4'd5:    begin down_tap = cells[5]; up_tap = cells[CELLS-5]; end
			4'd6:    begin down_tap = cells[6]; up_tap = cells[CELLS-6]; end
			4'd7:    begin down_tap = cells[7]; up_tap = cells[CELLS-7]; end
			default: begin down_tap = cells[8]; up_tap = cells[CELLS-8]; end
		endcase
	end

	always_comb begin
		nb     = cells[0];
		has_nb = 1'b0;
		unique case (sub_q)
			3'd1: begin nb = cells[CELLS-1]; has_nb = c_q != '0; end
			3'd2: begin nb = cells[1]; has_nb = (c_q + DW'(1)) < cols_eff; end
			3'd3: begin nb = up_tap; has_nb = r_q != '0; end
			3'd4: begin nb = down_tap; has_nb = (r_q + DW'(1)) < rows_eff; end
			default: ;
		endcase
	end

	always_comb begin
		op_a = ctls_pkg::MAC_HOLD;
		if (state_q == ctls_pkg::ST_VEL && active) begin
			unique case (sub_q)
				3'd0:    op_a = ctls_pkg::MAC_SPRING;
				3'd1, 3'd2, 3'd3, 3'd4:
					op_a = has_nb ? ctls_pkg::MAC_NEIGH : ctls_pkg::MAC_HOLD;
				3'd5:    op_a = ctls_pkg::MAC_KEEP;
				default: op_a = ctls_pkg::MAC_HOLD;
			endcase
		end
	end

	ctls_mac u_mac_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op_a),
		.pos     ({cells[0].a[14], cells[0].a}),
		.nb_pos  ({nb.a[14], nb.a}),
		.vel     ({{3{cells[0].va[12]}}, cells[0].va}),
		.coef    (sub_q == 3'd0 ? {1'b0, spring_q} :
			(sub_q == 3'd5 ? keep : {1'b0, coupling_q})),
		.lim     (ctls_pkg::LIM_VANGLE),
		.vel_new (va_new)
	);

	ctls_mac u_mac_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op_a),
		.pos     ({{2{cells[0].z[13]}}, cells[0].z}),
		.nb_pos  ({{2{nb.z[13]}}, nb.z}),
		.vel     ({{4{cells[0].vz[11]}}, cells[0].vz}),
		.coef    (sub_q == 3'd0 ? {1'b0, spring_q} :
			(sub_q == 3'd5 ? keep : {1'b0, coupling_q})),
		.lim     (ctls_pkg::LIM_VZOOM),
		.vel_new (vz_new)
	);

	assign a_sum = ctls_pkg::clamp17({{2{cells[0].a[14]}}, cells[0].a}
		+ {{4{cells[0].va[12]}}, cells[0].va}, ctls_pkg::LIM_ANGLE);
	assign z_sum = ctls_pkg::clamp17({{3{cells[0].z[13]}}, cells[0].z}
		+ {{5{cells[0].vz[11]}}, cells[0].vz}, ctls_pkg::LIM_ZOOM);

	always_comb begin
		upd = cells[0];
		if (active) begin
			if (state_q == ctls_pkg::ST_VEL) begin
				upd.va = va_new[12:0];
				upd.vz = vz_new[11:0];
			end else if (state_q == ctls_pkg::ST_POS) begin
				upd.a = a_sum[14:0];
				upd.z = z_sum[13:0];
			end
		end
	end

	always_comb begin
		adv = 1'b0;
		unique case (state_q)
			ctls_pkg::ST_VEL: adv = (sub_q == 3'd6) || !active;
			ctls_pkg::ST_POS: adv = !m_tvalid || m_tready;
			default:          adv = 1'b0;
		endcase
	end

	assign emit      = adv && active && state_q == ctls_pkg::ST_POS;
	assign phase_end = adv && i_q == IW'(CELLS - 1);

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		ctls_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (adv),
			.load_en  (in_acc && s_tuser == ctls_pkg::OP_LOAD &&
				s_tdata[IW-1:0] == IW'(k)),
			.next_d   ((k == CELLS - 1) ? upd : cells[(k + 1) % CELLS]),
			.load_d   (load_d),
			.tile_q   (cells[k])
		);
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ctls_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == ctls_pkg::OP_STEP) begin
					state_d = ctls_pkg::ST_VEL;
				end
			end
			ctls_pkg::ST_VEL: if (phase_end) state_d = ctls_pkg::ST_POS;
			ctls_pkg::ST_POS: if (phase_end) state_d = ctls_pkg::ST_IDLE;
			default: state_d = ctls_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			c_q   <= '0;
			r_q   <= '0;
			sub_q <= '0;
		end else if (adv) begin
			sub_q <= '0;
			if (phase_end) begin
				i_q <= '0;
				c_q <= '0;
				r_q <= '0;
			end else begin
				i_q <= i_q + IW'(1);
				if (c_q + DW'(1) == cols_eff) begin
					c_q <= '0;
					if (active) begin
						r_q <= r_q + DW'(1);
					end
				end else begin
					c_q <= c_q + DW'(1);
				end
			end
		end else if (state_q == ctls_pkg::ST_VEL) begin
			sub_q <= sub_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= {5'd0, upd.z, upd.a, i_q};
			m_tlast <= (r_q + DW'(1) == rows_eff) && (c_q + DW'(1) == cols_eff);
		end
	end

`ifndef ASSERT_OFF
	a_idle_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctls_pkg::ST_IDLE |-> i_q == '0 && c_q == '0 && r_q == '0)
		else $error("ring not aligned while idle");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		$signed(cells[0].a) <= ctls_pkg::LIM_ANGLE &&
		$signed(cells[0].a) >= -ctls_pkg::LIM_ANGLE)
		else $error("stored angle out of range");
	a_no_emit_in_vel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctls_pkg::ST_VEL |=> !emit || state_q == ctls_pkg::ST_POS)
		else $error("tile emitted during velocity pass");
	a_sub_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctls_pkg::ST_VEL && sub_q == 3'd6 |=> sub_q == 3'd0)
		else $error("velocity sequencer overran");
`endif

endmodule
